// File: rtl/core/pfd_pkg.sv
// Package for the pulse-width frame decoder.
// Holds field widths, phase and result codes and the window flag struct.
// No dependencies; every other file of the decoder imports it.
package pfd_pkg;

	localparam int IntervalW = 24;
	localparam int PeriodW   = 12;
	localparam int SyncW     = 8;
	localparam int BytesW    = 6;
	localparam int KindW     = 2;
	localparam int IndexW    = 8;
	localparam int CountW    = 9;
	localparam int CfgIdxW   = 2;
	localparam int CfgDataW  = 12;

	// Configuration register indexes
	localparam logic [CfgIdxW-1:0] CfgPeriod    = 2'd0;
	localparam logic [CfgIdxW-1:0] CfgTolerance = 2'd1;
	localparam logic [CfgIdxW-1:0] CfgSyncNeed  = 2'd2;
	localparam logic [CfgIdxW-1:0] CfgBytes     = 2'd3;

	// Register values after reset
	localparam logic [PeriodW-1:0] RstPeriod    = 12'd400;
	localparam logic [PeriodW-1:0] RstTolerance = 12'd100;
	localparam logic [SyncW-1:0]   RstSyncNeed  = 8'd8;
	localparam logic [BytesW-1:0]  RstBytes     = 6'd8;

	// Result kinds
	localparam logic [KindW-1:0] KindBit  = 2'd0;
	localparam logic [KindW-1:0] KindGood = 2'd1;
	localparam logic [KindW-1:0] KindBad  = 2'd2;

	typedef enum logic [1:0] {
		PH_SYNC   = 2'd0,
		PH_ANCHOR = 2'd1,
		PH_FIRST  = 2'd2,
		PH_SECOND = 2'd3
	} phase_t;

	// Interval matches against the 1T, 2T and 13T windows
	typedef struct packed {
		logic in1;
		logic in2;
		logic in13;
	} win_t;

endpackage

// File: rtl/core/pfd_edge_if.sv
// Input channel of the pulse-width frame decoder: one transaction per receiver edge.
// Depends on pfd_pkg for the field widths.
interface pfd_edge_if;
	import pfd_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [IntervalW-1:0] interval_us;
	logic                 silence;

	modport source (output valid, output interval_us, output silence, input ready);
	modport sink   (input valid, input interval_us, input silence, output ready);

endinterface

// File: rtl/core/pfd_result_if.sv
// Output channel of the pulse-width frame decoder: decoded bits and frame ends.
// Depends on pfd_pkg for the field widths.
interface pfd_result_if;
	import pfd_pkg::*;

	logic              valid;
	logic              ready;
	logic [KindW-1:0]  kind;
	logic              bit_value;
	logic [IndexW-1:0] bit_index;
	logic [CountW-1:0] bit_count;

	modport source (output valid, output kind, output bit_value, output bit_index,
		output bit_count, input ready);
	modport sink   (input valid, input kind, input bit_value, input bit_index,
		input bit_count, output ready);

endinterface

// File: rtl/core/pfd_window.sv
// Window matcher: tests one interval against T+-tol scaled by 1, 2 and 13.
// Depends on pfd_pkg. Purely combinational; constant scales become shifts and adds.
module pfd_window (
	input  logic [pfd_pkg::IntervalW-1:0] interval_us,
	input  logic [pfd_pkg::PeriodW-1:0]   clock_period_us,
	input  logic [pfd_pkg::PeriodW-1:0]   tolerance_us,
	output pfd_pkg::win_t                 win
);
	import pfd_pkg::*;

	logic [PeriodW-1:0]   lo;
	logic [PeriodW:0]     hi;
	logic [PeriodW+3:0]   lo13;
	logic [PeriodW+4:0]   hi13;

	// clamp the low bound at zero
	assign lo = (clock_period_us > tolerance_us) ? (clock_period_us - tolerance_us) : '0;
	assign hi = {1'b0, clock_period_us} + {1'b0, tolerance_us};

	// x*13 = 8x + 4x + x
	assign lo13 = {1'b0, lo, 3'b000} + {2'b00, lo, 2'b00} + {4'b0000, lo};
	assign hi13 = {1'b0, hi, 3'b000} + {2'b00, hi, 2'b00} + {4'b0000, hi};

	assign win.in1  = (interval_us >= IntervalW'(lo)) && (interval_us <= IntervalW'(hi));
	assign win.in2  = (interval_us >= IntervalW'({lo, 1'b0}))
		&& (interval_us <= IntervalW'({hi, 1'b0}));
	assign win.in13 = (interval_us >= IntervalW'(lo13)) && (interval_us <= IntervalW'(hi13));

endmodule

// File: rtl/core/pwm_pulse_frame_decoder_unit.sv
// Top level of the pulse-width frame decoder.
// Depends on pfd_pkg, pfd_edge_if, pfd_result_if and pfd_window.
//
// Usage:
//   edges   - valid/ready sink, one transaction per receiver edge: interval_us since
//             the previous edge, or silence = 1 when the external gap timer fired.
//   results - valid/ready source, at most one transaction per edge: a decoded bit
//             (kind bit, with bit_value and bit_index) or a frame end (good or bad,
//             with bit_count).
//   cfg_we/cfg_index/cfg_data - register writes (period, tolerance, sync pulses,
//             frame bytes), taken at once; write only while the decoder is idle.
// Path: an edge is registered in the input stage, where it is matched and decoded;
//   its result then loads the output register once that register is free.
// Throughput: one edge per cycle unless a result is blocked, set by the single input stage.
// Reset: phase returns to preamble sync, counters clear, registers take their
//   defaults (T = 400 us, tol = 100 us, 8 sync pulses, 8 bytes).
// Stall: the output register holds a waiting result; an edge that makes no result
//   still drains, and an edge that makes one waits in the input stage until the
//   output register frees, which then backs up the edges channel.
module pwm_pulse_frame_decoder_unit #(
	parameter int MAX_FRAME_BITS = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [pfd_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [pfd_pkg::CfgDataW-1:0] cfg_data,
	pfd_edge_if.sink                     edges,
	pfd_result_if.source                 results
);
	import pfd_pkg::*;

	localparam logic [CountW:0] MaxBits = (CountW + 1)'(MAX_FRAME_BITS);

	// configuration registers
	logic [PeriodW-1:0] period_q;
	logic [PeriodW-1:0] tol_q;
	logic [SyncW-1:0]   sync_need_q;
	logic [BytesW-1:0]  bytes_q;

	// input stage
	logic                 valid_s1;
	logic [IntervalW-1:0] interval_s1;
	logic                 silence_s1;

	// decoder state
	phase_t             phase_q, phase_d;
	logic [SyncW-1:0]   sync_run_q, sync_run_d;
	logic [CountW-1:0]  bits_q, bits_d;
	logic               cur_bit_q, cur_bit_d;

	// output register
	logic              out_valid_q;
	logic [KindW-1:0]  kind_q;
	logic              bit_value_q;
	logic [IndexW-1:0] bit_index_q;
	logic [CountW-1:0] bit_count_q;

	// result of the edge in the input stage
	logic              res_valid;
	logic [KindW-1:0]  res_kind;
	logic              res_bit;
	logic [IndexW-1:0] res_index;
	logic [CountW-1:0] res_count;

	win_t               win;
	logic [CountW:0]    limit_raw;
	logic [CountW:0]    limit;
	logic [SyncW-1:0]   run_inc;
	logic               out_free;
	logic               advance;
	logic               take;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= RstPeriod;
			tol_q       <= RstTolerance;
			sync_need_q <= RstSyncNeed;
			bytes_q     <= RstBytes;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CfgPeriod:    period_q    <= cfg_data;
				CfgTolerance: tol_q       <= cfg_data;
				CfgSyncNeed:  sync_need_q <= cfg_data[SyncW-1:0];
				CfgBytes:     bytes_q     <= cfg_data[BytesW-1:0];
				default:      ;
			endcase
		end
	end

	pfd_window u_window (
		.interval_us     (interval_s1),
		.clock_period_us (period_q),
		.tolerance_us    (tol_q),
		.win             (win)
	);

	// bit limit: 8 * frame_bytes, capped at the frame maximum
	assign limit_raw = {1'b0, bytes_q, 3'b000};
	assign limit     = (limit_raw > MaxBits) ? MaxBits : limit_raw;
	assign run_inc   = (sync_run_q == '1) ? sync_run_q : sync_run_q + 1'b1;

	// handshake: advance the input stage unless its result is blocked
	assign out_free     = !out_valid_q || results.ready;
	assign advance      = valid_s1 && (!res_valid || out_free);
	assign edges.ready  = !valid_s1 || advance;
	assign take         = edges.valid && edges.ready;

	// phase update and result for the edge in the input stage
	always_comb begin
		phase_d    = phase_q;
		sync_run_d = sync_run_q;
		bits_d     = bits_q;
		cur_bit_d  = cur_bit_q;
		res_valid  = 1'b0;
		res_kind   = KindBit;
		res_bit    = 1'b0;
		res_index  = '0;
		res_count  = '0;
		if (silence_s1) begin
			// silence only ends a frame in the data phase
			if (phase_q == PH_FIRST || phase_q == PH_SECOND) begin
				res_valid  = 1'b1;
				res_kind   = (bits_q != '0) ? KindGood : KindBad;
				res_count  = bits_q;
				phase_d    = PH_SYNC;
				sync_run_d = '0;
				bits_d     = '0;
			end
		end else begin
			unique case (phase_q)
				PH_SYNC: begin
					if (win.in1) begin
						if (run_inc >= sync_need_q) begin
							phase_d    = PH_ANCHOR;
							sync_run_d = '0;
						end else begin
							sync_run_d = run_inc;
						end
					end else begin
						sync_run_d = '0;
					end
				end
				PH_ANCHOR: begin
					if (win.in13) begin
						bits_d = '0;
						if (limit == '0) begin
							res_valid  = 1'b1;
							res_kind   = KindBad;
							phase_d    = PH_SYNC;
							sync_run_d = '0;
						end else begin
							phase_d = PH_FIRST;
						end
					end else if (!win.in1) begin
						// anything but preamble or anchor aborts the frame
						res_valid  = 1'b1;
						res_kind   = KindBad;
						phase_d    = PH_SYNC;
						sync_run_d = '0;
						bits_d     = '0;
					end
				end
				PH_FIRST: begin
					if (win.in2 || win.in1) begin
						res_valid = 1'b1;
						res_kind  = KindBit;
						res_bit   = win.in2;
						res_index = bits_q[IndexW-1:0];
						cur_bit_d = win.in2;
						if ({1'b0, bits_q} < MaxBits) begin
							bits_d = bits_q + 1'b1;
						end
						phase_d = PH_SECOND;
					end else begin
						res_valid  = 1'b1;
						res_kind   = KindBad;
						res_count  = bits_q;
						phase_d    = PH_SYNC;
						sync_run_d = '0;
						bits_d     = '0;
					end
				end
				PH_SECOND: begin
					// second half must have the complementary width
					if (cur_bit_q ? !win.in1 : !win.in2) begin
						res_valid  = 1'b1;
						res_kind   = KindBad;
						res_count  = bits_q;
						phase_d    = PH_SYNC;
						sync_run_d = '0;
						bits_d     = '0;
					end else if ({1'b0, bits_q} >= limit) begin
						res_valid  = 1'b1;
						res_kind   = KindGood;
						res_count  = bits_q;
						phase_d    = PH_SYNC;
						sync_run_d = '0;
						bits_d     = '0;
					end else begin
						phase_d = PH_FIRST;
					end
				end
				default: ;
			endcase
		end
	end

	// input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (edges.ready) begin
			valid_s1 <= edges.valid;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (take) begin
			interval_s1 <= edges.interval_us;
			silence_s1  <= edges.silence;
		end
	end

	// decoder state, updated when the staged edge retires
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_SYNC;
			sync_run_q <= '0;
			bits_q     <= '0;
			cur_bit_q  <= 1'b0;
		end else if (advance) begin
			phase_q    <= phase_d;
			sync_run_q <= sync_run_d;
			bits_q     <= bits_d;
			cur_bit_q  <= cur_bit_d;
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && res_valid;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_free && advance && res_valid) begin
			kind_q      <= res_kind;
			bit_value_q <= res_bit;
			bit_index_q <= res_index;
			bit_count_q <= res_count;
		end
	end

	assign results.valid     = out_valid_q;
	assign results.kind      = kind_q;
	assign results.bit_value = bit_value_q;
	assign results.bit_index = bit_index_q;
	assign results.bit_count = bit_count_q;

endmodule
